// ===== rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Constants, status codes and the character-to-sextet map of the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // stream status codes, carried with the final transfer of a stream
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

  // characters of the alphabet and the pad
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [7:0] LOWER_OFS  = 8'd26;
  localparam logic [7:0] DIGIT_OFS  = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // group layout
  localparam logic [1:0] POS_THIRD = 2'd2;
  localparam logic [1:0] POS_LAST  = 2'd3;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } sextet_t;

  // maps one character to its sextet, flags anything outside the alphabet
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t    r;
    logic [7:0] d;
    r.bad = 1'b0;
    r.val = '0;
    d     = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      d     = ch - CH_UPPER_A;
      r.val = d[5:0];
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      d     = ch - CH_LOWER_A + LOWER_OFS;
      r.val = d[5:0];
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      d     = ch - CH_DIGIT_0 + DIGIT_OFS;
      r.val = d[5:0];
    end else if (ch == CH_PLUS) begin
      r.val = SEXTET_PLUS;
    end else if (ch == CH_SLASH) begin
      r.val = SEXTET_SLASH;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 (standard alphabet) stream decoder, one character in per transfer.
// ----------------------------------------------------------------------------
// Takes one Base64 character per input transfer (tlast marks the last
// character of the encoded stream) and gives one decoded byte per output
// transfer. Characters group in fours from the start of the stream; the
// fourth character of a group loads the group register with up to three
// bytes, which leave one per cycle while not stalled. Characters in places
// 0..2 are taken every cycle without waiting on the output side. The fourth
// character of a group, and a tlast on a short group, are taken once the
// group register is empty or handing over its last byte, so a continuous
// stream runs at one character per cycle with a ready sink; the group register
// is the only point of back-pressure. On the final transfer of a stream,
// tuser carries a status: ok, invalid character (sticky over the stream), or
// bad length. A bad length gives a single status-only transfer (byte_valid
// low) and drops the partial group. Bytes are sent as soon as their group is
// complete, ahead of the status. Padding: '=' in place 2 of the last group
// gives one byte and the fourth character is ignored; '=' in place 3 only
// gives two bytes; '=' anywhere else counts as an invalid character.
// s_axis_tready depends combinationally on s_axis_tlast and m_axis_tready.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input character stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // stream_end
  // decoded byte stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tlast,   // run_last
  output logic [3:0] m_axis_tuser    // [0] byte_valid, [1] stream_done, [3:2] status
);

  // decoder state
  logic [1:0]  pos;        // place of the next character in its group
  logic [17:0] acc;        // sextets of places 0..2
  logic        pad_seen;   // '=' in place 2 of this group
  logic        err;        // invalid character seen in this stream

  // group register, drained one byte per transfer
  logic        out_busy;
  logic [23:0] out_bits;
  logic [1:0]  out_cnt;    // results held, 1..3
  logic [1:0]  out_idx;    // result now offered
  logic        out_end;    // group closes the stream
  logic        out_bytes;  // 0 for a status-only result
  logic [1:0]  out_status;

  logic        in_xfer;
  logic        out_xfer;
  logic        out_free;   // group register can take a new load this cycle
  logic        has_result; // the offered character produces transfers

  sextet_t     sx;
  logic        is_pad;
  logic [5:0]  sext;
  logic        err_next;
  logic        pad_next;
  logic [1:0]  cnt_next;
  logic [1:0]  status_next;
  logic [4:0]  shift_amt;
  logic [23:0] byte_sel;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign out_xfer   = m_axis_tvalid && m_axis_tready;
  assign out_free   = !out_busy || (out_xfer && (out_idx == out_cnt - 2'd1));
  assign has_result = (pos == POS_LAST) || s_axis_tlast;
  // places 0..2 wait on the output side only when they carry tlast
  assign s_axis_tready = !has_result || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // per-character decode
  // ---------------------------------------------------------------------
  always_comb begin
    sx          = sextet_of(s_axis_tdata);
    is_pad      = (s_axis_tdata == CH_PAD);
    sext        = sx.val;
    err_next    = err;
    pad_next    = pad_seen;
    cnt_next    = 2'd3;
    status_next = STATUS_OK;
    if (pos != POS_LAST) begin
      if (pos == POS_THIRD && is_pad) begin
        // pad in place 2 is fine only if the stream ends with this group
        pad_next = 1'b1;
        sext     = '0;
      end else if (sx.bad) begin
        err_next = 1'b1;
      end
      cnt_next    = 2'd1;
      status_next = STATUS_BAD_LEN;
    end else begin
      if (s_axis_tlast && pad_seen) begin
        // fourth character ignored after an early pad
        cnt_next = 2'd1;
        sext     = '0;
      end else if (s_axis_tlast && is_pad) begin
        cnt_next = 2'd2;
        sext     = '0;
      end else begin
        // a pad in place 2 of a middle group is an invalid character
        err_next = err || pad_seen || sx.bad;
        if (sx.bad) begin
          sext = '0;
        end
      end
      status_next = err_next ? STATUS_BAD_CHAR : STATUS_OK;
    end
  end

  // ---------------------------------------------------------------------
  // state and group register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      acc      <= '0;
      pad_seen <= 1'b0;
      err      <= 1'b0;
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else begin
      if (in_xfer && !has_result) begin
        // places 0..2: shift the sextet in
        acc      <= {acc[11:0], sext};
        pos      <= pos + 2'd1;
        pad_seen <= pad_next;
        err      <= err_next;
      end

      if (in_xfer && has_result) begin
        // group closes: load the group register, taking over from a last
        // result that leaves in the same cycle
        out_busy   <= 1'b1;
        out_idx    <= '0;
        out_cnt    <= cnt_next;
        out_end    <= s_axis_tlast;
        out_bytes  <= (pos == POS_LAST);
        out_bits   <= {acc, sext};
        out_status <= status_next;
        pos        <= '0;
        acc        <= '0;
        pad_seen   <= 1'b0;
        // the sticky error lasts until the stream ends
        err        <= s_axis_tlast ? 1'b0 : err_next;
      end else if (out_xfer) begin
        // drain one result per transfer
        if (out_idx == out_cnt - 2'd1) begin
          out_busy <= 1'b0;
        end else begin
          out_idx <= out_idx + 2'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // output fields, byte k of the group sits at bits [23-8k -: 8]
  // ---------------------------------------------------------------------
  assign shift_amt = {out_idx, 3'b000};
  assign byte_sel  = out_bits << shift_amt;

  always_comb begin
    m_axis_tvalid   = out_busy;
    m_axis_tdata    = out_bytes ? byte_sel[23:16] : 8'd0;
    m_axis_tlast    = (out_idx == out_cnt - 2'd1);
    m_axis_tuser[0] = out_bytes;
    m_axis_tuser[1] = m_axis_tlast && out_end;
    m_axis_tuser[3:2] = (m_axis_tlast && out_end) ? out_status : STATUS_OK;
  end

`ifndef SYNTH
  // the offered result always lies inside the loaded group
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    out_busy |-> (out_idx < out_cnt) && (out_cnt != 2'd0))
    else $error("result index beyond group");

  // a group load never overwrites results still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && has_result) |-> (!out_busy || (out_xfer && m_axis_tlast)))
    else $error("group register overwritten");

  // the end of a stream brings the decoder back to its start state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> (pos == 2'd0) && !err && !pad_seen)
    else $error("state not cleared at stream end");

  // a bad length is reported as a single status-only transfer
  a_bad_len_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tlast && m_axis_tuser[1] && m_axis_tuser[3:2] == STATUS_BAD_LEN))
    else $error("status-only transfer malformed");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Base64 stream decoder. Characters go in on the
// input stream, and an in-bench decoder predicts every byte and status
// transfer, which is matched field by field against the output stream.
// Directed streams cover the alphabet edges, padding, invalid characters and
// bad lengths. Random streams then run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import b64d_pkg::*;

  // no transfer on either side for this many cycles means the block is hung
  localparam int QUIET_LIMIT = 2000;
  // cycles to keep watching once every predicted transfer has arrived
  localparam int DRAIN_CYCLES = 10;

  // one predicted output transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
    logic [1:0] status;
  } dec_out_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
  logic       s_axis_tlast = 1'b0;    // stream_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] data_byte
  logic       m_axis_tlast;           // run_last
  logic [3:0] m_axis_tuser;           // [0] byte_valid, [1] stream_done, [3:2] status

  // decoder state mirrored in the bench
  logic [1:0]  dec_pos = '0;
  logic [17:0] dec_acc = '0;
  logic        dec_pad = 1'b0;
  logic        dec_err = 1'b0;

  dec_out_t   decoded_q[$];
  dec_out_t   got_out;
  dec_out_t   want_out;
  logic [7:0] stream_buf[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  base64_stream_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // {bad, sextet} for one character
  function automatic logic [6:0] char_sextet(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'd0;
    if (ch == CH_PLUS) return {1'b0, SEXTET_PLUS};
    if (ch == CH_SLASH) return {1'b0, SEXTET_SLASH};
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) v = ch - CH_UPPER_A;
    else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) v = ch - CH_LOWER_A + LOWER_OFS;
    else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) v = ch - CH_DIGIT_0 + DIGIT_OFS;
    else return {1'b1, 6'd0};
    return {1'b0, v[5:0]};
  endfunction

  // character of the alphabet for a sextet value
  function automatic logic [7:0] alpha_char(input int unsigned idx);
    if (idx < 26) return 8'(CH_UPPER_A + idx);
    if (idx < 52) return 8'(CH_LOWER_A + (idx - 26));
    if (idx < 62) return 8'(CH_DIGIT_0 + (idx - 52));
    if (idx == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic bv, input logic rl,
                             input logic sd, input logic [1:0] st);
    dec_out_t r;
    r.data_byte   = b;
    r.byte_valid  = bv;
    r.run_last    = rl;
    r.stream_done = sd;
    r.status      = st;
    decoded_q.push_back(r);
  endtask

  // advance the mirrored decoder by one accepted character
  task automatic decode_char(input logic [7:0] ch, input logic last);
    logic [6:0]  lk;
    logic [5:0]  sx;
    logic [23:0] word;
    int          nbytes;
    logic        fin;
    lk     = char_sextet(ch);
    sx     = 6'd0;
    nbytes = 3;
    if (dec_pos != POS_LAST) begin
      if (last) begin
        // short group: a single status-only transfer, partial group dropped
        push_result(8'h00, 1'b0, 1'b1, 1'b1, STATUS_BAD_LEN);
        dec_pos = '0;
        dec_acc = '0;
        dec_pad = 1'b0;
        dec_err = 1'b0;
      end else begin
        if (dec_pos == POS_THIRD && ch == CH_PAD) begin
          dec_pad = 1'b1;
        end else begin
          if (lk[6]) dec_err = 1'b1;
          sx = lk[5:0];
        end
        dec_acc = {dec_acc[11:0], sx};
        dec_pos = dec_pos + 2'd1;
      end
    end else begin
      if (last && dec_pad) begin
        nbytes = 1;       // fourth character not looked at
      end else if (last && ch == CH_PAD) begin
        nbytes = 2;
      end else begin
        if (dec_pad || lk[6]) dec_err = 1'b1;
        sx = lk[5:0];
      end
      word = {dec_acc, sx};
      for (int k = 0; k < nbytes; k++) begin
        fin = (k == nbytes - 1);
        push_result(word[23 - 8 * k -: 8], 1'b1, fin, fin && last,
                    (fin && last && dec_err) ? STATUS_BAD_CHAR : STATUS_OK);
      end
      dec_pos = '0;
      dec_acc = '0;
      dec_pad = 1'b0;
      if (last) dec_err = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // present one character, hold it until the transfer, then maybe idle
  task automatic send_char(input logic [7:0] ch, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_char(ch, last);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // whole string as one stream, end flag on the final character
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // --------------------------------------------------------------------------
  // output side: random stall and the result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_out = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
                 m_axis_tuser[3:2]};
      if (decoded_q.size() == 0) begin
        $error("unexpected output transfer: tdata %0h tlast %0b tuser %0h",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fail_count++;
      end else begin
        want_out = decoded_q.pop_front();
        if (got_out.data_byte !== want_out.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want_out.data_byte, got_out.data_byte);
          fail_count++;
        end
        if (got_out.byte_valid !== want_out.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want_out.byte_valid,
                 got_out.byte_valid);
          fail_count++;
        end
        if (got_out.run_last !== want_out.run_last) begin
          $error("run_last: expected %0b, got %0b", want_out.run_last, got_out.run_last);
          fail_count++;
        end
        if (got_out.stream_done !== want_out.stream_done) begin
          $error("stream_done: expected %0b, got %0b", want_out.stream_done,
                 got_out.stream_done);
          fail_count++;
        end
        if (got_out.status !== want_out.status) begin
          $error("status: expected %0d, got %0d", want_out.status, got_out.status);
          fail_count++;
        end
      end
    end
  end

  // hang detection: any transfer on either side resets the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[base64_stream_decoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // first and last letter of each range, digits, plus and slash
  task automatic test_alphabet();
    send_text("AZaz09+/");
  endtask

  // pad in the third place (fourth ignored, here all ones), pad in the fourth
  task automatic test_padding();
    send_text("QQ=\377");
    send_text("QUI=");
  endtask

  // non-alphabet byte and pad in a middle group, pad in place 1 of the last
  task automatic test_invalid_chars();
    send_text("\377B=AA=A=");
  endtask

  // end flag on place 2 after an invalid character: length wins
  task automatic test_bad_length();
    send_text("\200B=");
  endtask

  // mostly well-formed streams with random content, some broken or noise
  task automatic test_random_streams(input int n_items);
    int sent;
    int kind;
    int ngroups;
    int npad;
    int nchar;
    logic [7:0] c;
    sent = 0;
    while (sent < n_items) begin
      stream_buf.delete();
      kind = $urandom_range(9);
      if (kind == 9) begin
        // raw noise, 1 to 12 characters
        nchar = $urandom_range(1, 12);
        repeat (nchar) stream_buf.push_back(8'($urandom_range(255)));
      end else begin
        ngroups = $urandom_range(1, 3);
        npad    = $urandom_range(3);
        npad    = (npad < 2) ? 0 : npad - 1;
        nchar   = 4 * ngroups;
        for (int i = 0; i < nchar; i++) begin
          c = alpha_char($urandom_range(63));
          if (npad == 2 && i == nchar - 2) c = CH_PAD;
          if (npad == 2 && i == nchar - 1)
            c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CH_PAD;
          if (npad == 1 && i == nchar - 1) c = CH_PAD;
          stream_buf.push_back(c);
        end
        case (kind)
          6: stream_buf[$urandom_range(nchar - 1)] = CH_PAD;
          7: stream_buf[$urandom_range(nchar - 1)] = 8'($urandom_range(255));
          8: repeat ($urandom_range(1, 3)) void'(stream_buf.pop_back());
          default: ;
        endcase
      end
      for (int i = 0; i < stream_buf.size(); i++)
        send_char(stream_buf[i], i == stream_buf.size() - 1);
      sent += stream_buf.size();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_alphabet();
    test_padding();
    test_invalid_chars();
    test_bad_length();

    test_random_streams(80);
    src_idle_pct   = 79;
    test_random_streams(80);
    src_idle_pct   = 0;
    sink_stall_pct = 79;
    test_random_streams(80);
    src_idle_pct   = 8;
    sink_stall_pct = 8;
    test_random_streams(80);

    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[base64_stream_decoder] OK");
    end else begin
      $display("[base64_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/b64d_pkg.sv
rtl/base64_stream_decoder.sv
sim/tb_top.sv
